### sv/rfh_pkg.sv
// rfh_pkg: shared types and constants of the row fir filter with halo
// used by rfh_cell, rfh_sum and row_fir_with_halo_top
// no dependencies
package rfh_pkg;

    // window and arithmetic sizes
    localparam int MAX_TAPS    = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int PROD_W      = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W       = PROD_W + 3;
    localparam int Q_W         = ACC_W - FRAC_BITS;
    localparam int TAP_W       = $clog2(MAX_TAPS + 1);
    localparam int FILL_W      = $clog2(MAX_TAPS);

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_6   = CFG_IDX_W'(7);

    localparam logic [TAP_W-1:0]  TAP_COUNT_RESET = TAP_W'(3);
    localparam logic [FILL_W-1:0] FILL_MAX        = FILL_W'(MAX_TAPS - 1);

    // rounding and saturation
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 <<< (FRAC_BITS - 1));
    localparam logic signed [Q_W-1:0]   SAT_HI     = Q_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_LO     = Q_W'(-(1 <<< (SAMPLE_BITS - 1)));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEFF_BITS-1:0]  coeff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    localparam coeff_t COEFF_1_RESET = COEFF_BITS'(16384);

    // control that travels with one transaction through the adder pipeline
    typedef struct packed {
        logic valid;
        logic row_end;
        logic frame_end;
    } rfh_ctl_t;

endpackage

### sv/rfh_cell.sv
// rfh_cell: one tap of the sample window, holds one delayed sample and the
// registered product of the sample it sees with its coefficient
// depends on rfh_pkg
module rfh_cell
    import rfh_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  sample_t tap_in,
    input  coeff_t  coeff,
    input  logic    enable_tap,
    output sample_t tap_out,
    output prod_t   prod
);

    sample_t win_reg;
    prod_t   prod_reg;
    prod_t   prod_next;

    // product of this tap, zero when the tap is beyond the active length
    always_comb
    begin
        if (enable_tap)
        begin
            prod_next = PROD_W'(coeff) * PROD_W'(tap_in);
        end
        else
        begin
            prod_next = '0;
        end
    end

    // window register and product register advance on each accepted sample
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_reg  <= tap_in;
            prod_reg <= prod_next;
        end
    end

    assign tap_out = win_reg;
    assign prod    = prod_reg;

endmodule

### sv/rfh_sum.sv
// rfh_sum: registered adder tree over the tap products, then rounding,
// shift and saturation into the output register
// depends on rfh_pkg
module rfh_sum
    import rfh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rfh_ctl_t ctl_in,
    input  prod_t    prod [MAX_TAPS],
    output logic     take,
    input  logic     out_ready,
    output logic     out_valid,
    output sample_t  filtered_sample,
    output logic     row_end_out,
    output logic     frame_end_out
);

    rfh_ctl_t ctl2_reg;
    rfh_ctl_t ctl3_reg;
    rfh_ctl_t out_ctl_reg;
    acc_t     a01_reg;
    acc_t     a23_reg;
    acc_t     a45_reg;
    acc_t     a6_reg;
    acc_t     b0_reg;
    acc_t     b1_reg;
    sample_t  result_reg;
    sample_t  result_next;
    acc_t     total;
    logic signed [Q_W-1:0] quot;
    logic     en2;
    logic     en3;
    logic     en4;

    // per stage advance: a stage moves when its successor is free or moving
    assign en4  = !out_ctl_reg.valid || out_ready;
    assign en3  = !ctl3_reg.valid || en4;
    assign en2  = !ctl2_reg.valid || en3;
    assign take = !ctl_in.valid || en2;

    // final sum, floor shift and saturation
    always_comb
    begin
        total = b0_reg + b1_reg;
        quot  = total[ACC_W-1:FRAC_BITS];
        if (quot > SAT_HI)
        begin
            result_next = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (quot < SAT_LO)
        begin
            result_next = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            result_next = quot[SAMPLE_BITS-1:0];
        end
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            out_ctl_reg <= '0;
        end
        else
        begin
            if (en2)
            begin
                ctl2_reg <= ctl_in;
            end
            if (en3)
            begin
                ctl3_reg <= ctl2_reg;
            end
            if (en4)
            begin
                out_ctl_reg <= ctl3_reg;
            end
        end
    end

    // data of the three stages
    always_ff @(posedge clk)
    begin
        if (en2 && ctl_in.valid)
        begin
            a01_reg <= ACC_W'(prod[0]) + ACC_W'(prod[1]);
            a23_reg <= ACC_W'(prod[2]) + ACC_W'(prod[3]);
            a45_reg <= ACC_W'(prod[4]) + ACC_W'(prod[5]);
            a6_reg  <= ACC_W'(prod[6]);
        end
        if (en3 && ctl2_reg.valid)
        begin
            b0_reg <= a01_reg + a23_reg;
            b1_reg <= a45_reg + a6_reg + ROUND_HALF;
        end
        if (en4 && ctl3_reg.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_ctl_reg.valid;
    assign filtered_sample = result_reg;
    assign row_end_out     = out_ctl_reg.row_end;
    assign frame_end_out   = out_ctl_reg.frame_end;

`ifndef SYNTH
    // upstream is held back only when every stage is occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !take |-> (ctl_in.valid && ctl2_reg.valid && ctl3_reg.valid && out_ctl_reg.valid))
        else $error("pipeline stalls with a free stage");
`endif

endmodule

### sv/row_fir_with_halo_top.sv
// row_fir_with_halo_top: horizontal odd length fir over halo extended rows
// depends on rfh_pkg, rfh_cell and rfh_sum
//
// usage
//   input channel in_valid/in_ready carries sample_in, row_end_in and
//   frame_end_in; per row send the left halo, the row, then the right halo.
//   output channel out_valid/out_ready carries filtered_sample, row_end_out
//   and frame_end_out. an input transaction gives a result once the window
//   holds tap_count|1 samples of the current row; earlier ones give nothing.
//   configuration writes on cfg_valid/cfg_ready (always ready): index 0 is
//   tap_count, 1 to 7 are coeff_0 to coeff_6, higher indexes are ignored.
//   write only while the block is idle.
// timing
//   one transaction per cycle sustained while out_ready is high. a chain of
//   seven tap cells shifts the window and registers the products in the accept
//   cycle, a two level registered adder tree follows, and the rounded,
//   saturated result is then registered in the output register.
// reset and stall
//   reset empties the pipeline, clears the window fill and loads tap_count 3,
//   coeff_1 = 1.0 and all other coefficients 0. when out_ready is low the
//   pipeline stages fill one by one and in_ready falls only once all are full.
module row_fir_with_halo_top
    import rfh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sample_t               sample_in,
    input  logic                  row_end_in,
    input  logic                  frame_end_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sample_t               filtered_sample,
    output logic                  row_end_out,
    output logic                  frame_end_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TAP_W-1:0]  tap_count_reg;
    coeff_t            coeff_reg [MAX_TAPS];
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    rfh_ctl_t          ctl1_reg;
    rfh_ctl_t          ctl1_next;
    logic [TAP_W-1:0]  taps_use;
    logic [TAP_W-1:0]  taps_less;
    logic [MAX_TAPS-1:0] tap_mask;
    logic              produce;
    logic              accept;
    logic              take;
    logic [CFG_IDX_W-1:0] coeff_sel;
    sample_t           tap_chain [MAX_TAPS+1];
    prod_t             prod [MAX_TAPS];

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign in_ready  = take;

    // active tap count: forced odd
    assign taps_use  = tap_count_reg | TAP_W'(1);
    assign taps_less = taps_use - TAP_W'(1);
    assign produce   = fill_count_reg >= FILL_W'(taps_less);
    assign coeff_sel = cfg_index - REG_COEFF_0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coeff_reg[i] <= '0;
            end
            coeff_reg[1] <= COEFF_1_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[TAP_W-1:0];
            end
            else if (cfg_index <= REG_COEFF_6)
            begin
                coeff_reg[coeff_sel[TAP_W-1:0]] <= cfg_data;
            end
        end
    end

    // window fill and stage one control
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (row_end_in || frame_end_in)
        begin
            fill_count_next = '0;
        end
        else if (fill_count_reg < FILL_MAX)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
        ctl1_next.valid     = accept && produce;
        ctl1_next.row_end   = row_end_in;
        ctl1_next.frame_end = frame_end_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            ctl1_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
            end
            if (take)
            begin
                ctl1_reg <= ctl1_next;
            end
        end
    end

    // chain of tap cells, the newest sample enters at cell zero
    assign tap_chain[0] = sample_in;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        assign tap_mask[k] = TAP_W'(k) < taps_use;

        rfh_cell u_cell (
            .clk        (clk),
            .shift      (accept),
            .tap_in     (tap_chain[k]),
            .coeff      (coeff_reg[k]),
            .enable_tap (tap_mask[k]),
            .tap_out    (tap_chain[k+1]),
            .prod       (prod[k])
        );
    end

    // adder tree and output register
    rfh_sum u_sum (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl_in          (ctl1_reg),
        .prod            (prod),
        .take            (take),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .filtered_sample (filtered_sample),
        .row_end_out     (row_end_out),
        .frame_end_out   (frame_end_out)
    );

`ifndef SYNTH
    // a row or frame end restarts the window fill
    a_fill_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (row_end_in || frame_end_in) |=> fill_count_reg == '0)
        else $error("window fill not restarted at row end");
`endif

`ifndef SYNTH
    // fill grows by one per sample inside a row until saturated
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_end_in && !frame_end_in && fill_count_reg < FILL_MAX
        |=> fill_count_reg == $past(fill_count_reg) + FILL_W'(1))
        else $error("window fill did not advance");
`endif

`ifndef SYNTH
    // a sample arriving before the window is full gives no result
    a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !produce |=> !ctl1_reg.valid)
        else $error("result issued for an incomplete window");
`endif

endmodule
